// ----- rtl/ist_pkg.sv -----
// ----------------------------------------------------------------------------
// ist_pkg
// Shared types and codes for the interval set range tracker.
// ----------------------------------------------------------------------------
package ist_pkg;

	// Operation codes
	localparam logic [1:0] K_ADD    = 2'd0;
	localparam logic [1:0] K_REMOVE = 2'd1;
	localparam logic [1:0] K_QUERY  = 2'd2;
	localparam logic [1:0] K_RSVD   = 2'd3;

	// Result status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam int COUNT_W = 5;

	typedef struct packed {
		logic               covered;
		logic [1:0]         status;
		logic [COUNT_W-1:0] interval_count;
	} result_t;

endpackage

// ----- rtl/ist_if.sv -----
// ----------------------------------------------------------------------------
// ist_req_if / ist_rsp_if
// Valid/ready channels for range items and their results.
// ----------------------------------------------------------------------------
interface ist_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] range_start;
	logic [31:0] range_end;

	modport source(output valid, kind, range_start, range_end, input ready);
	modport sink(input valid, kind, range_start, range_end, output ready);
endinterface

interface ist_rsp_if;
	logic       valid;
	logic       ready;
	logic       covered;
	logic [1:0] status;
	logic [4:0] interval_count;

	modport source(output valid, covered, status, interval_count, input ready);
	modport sink(input valid, covered, status, interval_count, output ready);
endinterface

// ----- rtl/ist_core.sv -----
// ----------------------------------------------------------------------------
// ist_core
// Interval table memory and the sequencer that scans it for each add, remove
// or query and rebuilds it in place for an add or remove.
// ----------------------------------------------------------------------------
module ist_core #(
	parameter int MAX_INTERVALS = 16,
	parameter int ADDR_BITS     = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [1:0]             kind,
	input  logic [ADDR_BITS-1:0]   lft,
	input  logic [ADDR_BITS-1:0]   rgt,
	output logic                   idle,
	output logic                   res_valid,
	input  logic                   res_take,
	output ist_pkg::result_t       res
);
	import ist_pkg::*;

	localparam int AW = ADDR_BITS;
	localparam int IW = $clog2(MAX_INTERVALS);
	localparam int CW = $clog2(MAX_INTERVALS + 1);
	localparam logic [CW:0] MAX_C = (CW + 1)'(MAX_INTERVALS);

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_SCAN_RD = 8'b0000_0010,
		S_SCAN_EV = 8'b0000_0100,
		S_PLAN    = 8'b0000_1000,
		S_NEW_WR  = 8'b0001_0000,
		S_CP_RD   = 8'b0010_0000,
		S_CP_WR   = 8'b0100_0000,
		S_FIN     = 8'b1000_0000
	} state_t;

	state_t state_q;

	// Table memory: {start, end} per entry
	logic [2*AW-1:0] mem [MAX_INTERVALS];
	logic [2*AW-1:0] rdata;
	logic            we;
	logic [IW-1:0]   waddr;
	logic [2*AW-1:0] wdata;
	logic [AW-1:0]   rd_s, rd_e;

	logic [1:0]    kind_q;
	logic [AW-1:0] lft_q, rgt_q;
	logic [CW-1:0] cnt_q, ncnt_q, idx_q, lo_q, nm_q, hi_q;
	logic          found_q, covered_q, commit_q, grow_q, wi_q;
	logic [1:0]    status_q, np_q;
	logic [AW-1:0] fs_q, fe_q, le_q;
	logic [AW-1:0] ns0_q, ne0_q;

	// Plan values
	logic [CW-1:0] hi_c;
	logic          p0, p1;
	logic [1:0]    np_c;
	logic [CW:0]   ncnt_c;
	logic          full_c, grow_c;
	logic [AW-1:0] ns_c, ne_c;
	logic [CW-1:0] nw_addr, dest;

	assign rd_s = rdata[2*AW-1:AW];
	assign rd_e = rdata[AW-1:0];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[idx_q[IW-1:0]];
	end

	// Plan: matched span, new pieces and resulting count
	always_comb begin
		hi_c = lo_q + nm_q;
		p0   = fs_q < lft_q;
		p1   = rgt_q < le_q;
		if (kind_q == K_ADD) begin
			np_c = 2'd1;
			ns_c = (found_q && fs_q < lft_q) ? fs_q : lft_q;
			ne_c = (found_q && le_q > rgt_q) ? le_q : rgt_q;
		end else begin
			np_c = {1'b0, p0} + {1'b0, p1};
			ns_c = p0 ? fs_q : rgt_q;
			ne_c = p0 ? lft_q : le_q;
		end
		ncnt_c = {1'b0, cnt_q} - {1'b0, nm_q} + (CW + 1)'(np_c);
		full_c = ncnt_c > MAX_C;
		grow_c = CW'(np_c) > nm_q;
	end

	// Memory write side
	always_comb begin
		nw_addr = lo_q + CW'(wi_q);
		dest    = grow_q ? idx_q + CW'(1) : idx_q - (nm_q - CW'(np_q));
		we      = 1'b0;
		waddr   = nw_addr[IW-1:0];
		wdata   = wi_q ? {rgt_q, le_q} : {ns0_q, ne0_q};
		if (state_q == S_NEW_WR) begin
			we = 1'b1;
		end else if (state_q == S_CP_WR) begin
			we    = 1'b1;
			waddr = dest[IW-1:0];
			wdata = rdata;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			ncnt_q    <= '0;
			idx_q     <= '0;
			lo_q      <= '0;
			nm_q      <= '0;
			hi_q      <= '0;
			found_q   <= 1'b0;
			covered_q <= 1'b0;
			commit_q  <= 1'b0;
			grow_q    <= 1'b0;
			wi_q      <= 1'b0;
			status_q  <= ST_DONE;
			np_q      <= '0;
			kind_q    <= K_ADD;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						kind_q    <= kind;
						lft_q     <= lft;
						rgt_q     <= rgt;
						lo_q      <= '0;
						nm_q      <= '0;
						idx_q     <= '0;
						found_q   <= 1'b0;
						covered_q <= 1'b0;
						commit_q  <= 1'b0;
						status_q  <= ST_DONE;
						if (lft >= rgt) begin
							status_q <= ST_EMPTY;
							state_q  <= S_FIN;
						end else if (kind == K_RSVD) begin
							state_q <= S_FIN;
						end else if (cnt_q == '0) begin
							state_q <= S_PLAN;
						end else begin
							state_q <= S_SCAN_RD;
						end
					end
				end
				S_SCAN_RD: state_q <= S_SCAN_EV;
				S_SCAN_EV: begin
					if (rd_e < lft_q) begin
						lo_q <= lo_q + CW'(1);
					end else if (rd_s <= rgt_q) begin
						if (!found_q) begin
							found_q <= 1'b1;
							fs_q    <= rd_s;
							fe_q    <= rd_e;
						end
						le_q <= rd_e;
						nm_q <= nm_q + CW'(1);
					end
					if (idx_q + CW'(1) == cnt_q) begin
						state_q <= S_PLAN;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_SCAN_RD;
					end
				end
				S_PLAN: begin
					hi_q   <= hi_c;
					np_q   <= np_c;
					ns0_q  <= ns_c;
					ne0_q  <= ne_c;
					ncnt_q <= ncnt_c[CW-1:0];
					grow_q <= grow_c;
					wi_q   <= 1'b0;
					if (kind_q == K_QUERY) begin
						covered_q <= found_q && fs_q <= lft_q && rgt_q <= fe_q;
						state_q   <= S_FIN;
					end else if (kind_q == K_REMOVE && !found_q) begin
						state_q <= S_FIN;
					end else if (full_c) begin
						status_q <= ST_FULL;
						state_q  <= S_FIN;
					end else begin
						commit_q <= 1'b1;
						if (grow_c) begin
							// make room: move the tail up by one, top entry first
							if (hi_c < cnt_q) begin
								idx_q   <= cnt_q - CW'(1);
								state_q <= S_CP_RD;
							end else begin
								state_q <= S_NEW_WR;
							end
						end else if (np_c != 2'd0) begin
							state_q <= S_NEW_WR;
						end else if (hi_c < cnt_q) begin
							idx_q   <= hi_c;
							state_q <= S_CP_RD;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_NEW_WR: begin
					wi_q <= 1'b1;
					if ({1'b0, wi_q} + 2'd1 == np_q) begin
						if (grow_q) begin
							state_q <= S_FIN;
						end else if (hi_q < cnt_q) begin
							idx_q   <= hi_q;
							state_q <= S_CP_RD;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_CP_RD: state_q <= S_CP_WR;
				S_CP_WR: begin
					if (grow_q) begin
						if (idx_q == hi_q) begin
							state_q <= S_NEW_WR;
						end else begin
							idx_q   <= idx_q - CW'(1);
							state_q <= S_CP_RD;
						end
					end else if (idx_q + CW'(1) == cnt_q) begin
						state_q <= S_FIN;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_CP_RD;
					end
				end
				S_FIN: begin
					if (res_take) begin
						if (commit_q) begin
							cnt_q <= ncnt_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign idle                 = state_q == S_IDLE;
	assign res_valid            = state_q == S_FIN;
	assign res.covered          = covered_q;
	assign res.status           = status_q;
	assign res.interval_count   = COUNT_W'(commit_q ? ncnt_q : cnt_q);

endmodule

// ----- rtl/interval_set_range_tracker.sv -----
// ----------------------------------------------------------------------------
// interval_set_range_tracker
// Sorted table of disjoint half-open intervals with add, remove and query.
// ----------------------------------------------------------------------------
// One item is in work at a time. An item is started, then each stored
// entry is scanned (one memory read, one evaluate), the plan is made,
// each new piece is written, and each entry of the table tail that moves
// is read and written, before the result goes to the output register; an
// empty range goes straight to the result. The single read port of the
// table memory makes every scan and move step a read and then a use.
// The result sits in an output register, so the next item is taken while it
// waits.
module interval_set_range_tracker #(
	parameter int MAX_INTERVALS = 16,
	parameter int ADDR_BITS     = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	ist_req_if.sink   req,
	ist_rsp_if.source rsp
);
	import ist_pkg::*;

	logic    idle, res_valid, res_take;
	result_t res;
	result_t rsp_q;
	logic    rsp_valid_q;

	ist_core #(
		.MAX_INTERVALS(MAX_INTERVALS),
		.ADDR_BITS    (ADDR_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (req.valid && idle),
		.kind     (req.kind),
		.lft      (ADDR_BITS'(req.range_start)),
		.rgt      (ADDR_BITS'(req.range_end)),
		.idle     (idle),
		.res_valid(res_valid),
		.res_take (res_take),
		.res      (res)
	);

	assign req.ready = idle;
	assign res_take  = res_valid && (!rsp_valid_q || rsp.ready);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.covered        = rsp_q.covered;
	assign rsp.status         = rsp_q.status;
	assign rsp.interval_count = rsp_q.interval_count;

endmodule

// ----- rtl/ist_chk.sv -----
// ----------------------------------------------------------------------------
// ist_chk
// Port-level checks for the interval set range tracker, bound to the top.
// ----------------------------------------------------------------------------
module ist_chk #(
	parameter int MAX_INTERVALS = 16
) (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       covered,
	input logic [1:0] status,
	input logic [4:0] interval_count
);
	import ist_pkg::*;

	// a stalled result stays up
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	// one item at a time: ready drops after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("input taken while busy");

	// covered only on a completed item
	a_cov_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && covered |-> status == ST_DONE)
		else $error("covered with non-done status");

	// status code and count in range
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (status == ST_DONE || status == ST_FULL || status == ST_EMPTY)
			&& int'(interval_count) <= MAX_INTERVALS)
		else $error("bad status or count");

endmodule

bind interval_set_range_tracker ist_chk #(.MAX_INTERVALS(MAX_INTERVALS)) u_ist_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.covered       (rsp.covered),
	.status        (rsp.status),
	.interval_count(rsp.interval_count)
);
